// ----- design/pgwa_pkg.sv -----
// Package for the profile gap width averager: shared ALU types, register
// indexes, reset values and widths.
// No dependencies.
package pgwa_pkg;

  // Shared ALU datapath width: covers 32-bit gap sum and signed 25-bit steps.
  localparam int ALU_W = 34;

  localparam int COORD_W = 24;
  localparam int GAP_W   = 25;
  localparam int SUM_W   = 32;
  localparam int CNT_W   = 7;
  localparam int IDX_W   = 3;

  localparam logic [CNT_W-1:0] SET_MAX = 7'd64;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_RISE_LOW  = 3'd0;
  localparam logic [IDX_W-1:0] REG_RISE_HIGH = 3'd1;
  localparam logic [IDX_W-1:0] REG_FALL_LOW  = 3'd2;
  localparam logic [IDX_W-1:0] REG_FALL_HIGH = 3'd3;
  localparam logic [IDX_W-1:0] REG_PER_SET   = 3'd4;

  // Register reset values
  localparam logic signed [COORD_W-1:0] RISE_LOW_RST  = 24'sd5000;
  localparam logic signed [COORD_W-1:0] RISE_HIGH_RST = 24'sd10000;
  localparam logic signed [COORD_W-1:0] FALL_LOW_RST  = -24'sd2800;
  localparam logic signed [COORD_W-1:0] FALL_HIGH_RST = -24'sd2600;
  localparam logic [CNT_W-1:0]          PER_SET_RST   = 7'd20;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

endpackage

// ----- design/pgwa_alu.sv -----
// Shared add/subtract unit of the gap averager; the sequencer's height step,
// window compares, gap, sum, divide and sign fix steps all run through it.
// Depends on pgwa_pkg.
module pgwa_alu (
  input  pgwa_pkg::alu_req_t              req,
  output logic [pgwa_pkg::ALU_W-1:0]      res
);
  import pgwa_pkg::*;

  // Single adder; subtract as a plus inverted b plus one
  always_comb begin
    case (req.op)
      ALU_SUB: res = req.a + ~req.b + {{(ALU_W-1){1'b0}}, 1'b1};
      default: res = req.a + req.b;
    endcase
  end

endmodule

// ----- design/profile_gap_width_averager_core.sv -----
// Channel  | Beat fields (low bit up)                       | Handshake
// in_      | tdata: x_um[23:0], z_um[47:24]; tlast: last    | tvalid/tready
// out_     | tdata: average_gap_um[24:0], good_profiles     | tvalid/tready
//          | [31:25]; tuser: no_good_profile                |
// cfg_     | cfg_addr index, cfg_wdata value                | cfg_we
//
// Datapath arithmetic goes through one shared add/subtract unit under a
// sequencer. An invalid non-final point is taken in the idle state alone; a
// valid point with a previous point runs the step, four window compares and
// update; a profile end adds end, profile count and, with both edges found,
// gap and sum. A set end adds the 32-step restoring divide plus sign handling.
// Reset is synchronous, active low; no clearing pass. A result waits in the
// output register; input is taken only in idle and is stalled while busy.
module profile_gap_width_averager_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [47:0]                      in_tdata,   // x_um, z_um
  input  logic                             in_tlast,   // last_point
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [31:0]                      out_tdata,  // average_gap_um, good_profiles
  output logic                             out_tuser,  // no_good_profile
  input  logic                             cfg_we,
  input  logic [pgwa_pkg::IDX_W-1:0]       cfg_addr,
  input  logic [pgwa_pkg::COORD_W-1:0]     cfg_wdata
);
  import pgwa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DZ, S_RL, S_RH, S_FL, S_FH, S_UPD,
    S_END, S_GAP, S_ACC, S_CNT, S_ABS, S_DIV, S_SIGN, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic signed [COORD_W-1:0] rise_lo_r, rise_hi_r, fall_lo_r, fall_hi_r;
  logic [CNT_W-1:0]          per_set_r;

  // control state
  logic              have_prev_r, have_prev_nxt;
  logic              left_found_r, left_found_nxt;
  logic              right_found_r, right_found_nxt;
  logic [CNT_W-1:0]  prof_idx_r, prof_idx_nxt;
  logic [CNT_W-1:0]  good_cnt_r, good_cnt_nxt;
  logic [SUM_W-1:0]  gap_sum_r, gap_sum_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload
  logic [COORD_W-1:0] x_r, x_nxt, z_r, z_nxt;
  logic               last_r, last_nxt;
  logic [COORD_W-1:0] prev_x_r, prev_x_nxt, prev_z_r, prev_z_nxt;
  logic [COORD_W-1:0] left_x_r, left_x_nxt, right_x_r, right_x_nxt;
  logic [GAP_W-1:0]   dz_r, dz_nxt, gap_r, gap_nxt, avg_r, avg_nxt;
  logic [3:0]         hit_r, hit_nxt;   // rise low, rise high, fall low, fall high
  logic               neg_r, neg_nxt;
  logic [SUM_W-1:0]   quo_r, quo_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [GAP_W-1:0]   out_avg_r, out_avg_nxt;
  logic [CNT_W-1:0]   out_good_r, out_good_nxt;
  logic               out_nogood_r, out_nogood_nxt;

  alu_req_t         alu_req;
  logic [ALU_W-1:0] alu_res;
  logic             alu_neg;

  logic             in_beat;
  logic [CNT_W-1:0] pi_inc, limit;

  pgwa_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign alu_neg   = alu_res[ALU_W-1];
  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_good_r, out_avg_r};
  assign out_tuser  = out_nogood_r;

  // saturated profile count and clamped set size
  assign pi_inc = (prof_idx_r < SET_MAX) ? prof_idx_r + 7'd1 : prof_idx_r;
  always_comb begin
    if (per_set_r == '0)          limit = 7'd1;
    else if (per_set_r > SET_MAX) limit = SET_MAX;
    else                          limit = per_set_r;
  end

  // ALU operand select per sequencer step
  always_comb begin
    alu_req.op = ALU_SUB;
    alu_req.a  = '0;
    alu_req.b  = '0;
    unique case (state_r)
      S_DZ: begin
        alu_req.a = {{(ALU_W-COORD_W){z_r[COORD_W-1]}}, z_r};
        alu_req.b = {{(ALU_W-COORD_W){prev_z_r[COORD_W-1]}}, prev_z_r};
      end
      S_RL: begin
        alu_req.a = {{(ALU_W-COORD_W){rise_lo_r[COORD_W-1]}}, rise_lo_r};
        alu_req.b = {{(ALU_W-GAP_W){dz_r[GAP_W-1]}}, dz_r};
      end
      S_RH: begin
        alu_req.a = {{(ALU_W-GAP_W){dz_r[GAP_W-1]}}, dz_r};
        alu_req.b = {{(ALU_W-COORD_W){rise_hi_r[COORD_W-1]}}, rise_hi_r};
      end
      S_FL: begin
        alu_req.a = {{(ALU_W-COORD_W){fall_lo_r[COORD_W-1]}}, fall_lo_r};
        alu_req.b = {{(ALU_W-GAP_W){dz_r[GAP_W-1]}}, dz_r};
      end
      S_FH: begin
        alu_req.a = {{(ALU_W-GAP_W){dz_r[GAP_W-1]}}, dz_r};
        alu_req.b = {{(ALU_W-COORD_W){fall_hi_r[COORD_W-1]}}, fall_hi_r};
      end
      S_GAP: begin
        alu_req.a = {{(ALU_W-COORD_W){right_x_r[COORD_W-1]}}, right_x_r};
        alu_req.b = {{(ALU_W-COORD_W){left_x_r[COORD_W-1]}}, left_x_r};
      end
      S_ACC: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = {{(ALU_W-SUM_W){gap_sum_r[SUM_W-1]}}, gap_sum_r};
        alu_req.b  = {{(ALU_W-GAP_W){gap_r[GAP_W-1]}}, gap_r};
      end
      S_ABS: begin
        alu_req.b = {{(ALU_W-SUM_W){gap_sum_r[SUM_W-1]}}, gap_sum_r};
      end
      S_DIV: begin
        alu_req.a = {{(ALU_W-CNT_W-1){1'b0}}, rem_r, quo_r[SUM_W-1]};
        alu_req.b = {{(ALU_W-CNT_W){1'b0}}, good_cnt_r};
      end
      S_SIGN: begin
        alu_req.b = {{(ALU_W-SUM_W){1'b0}}, quo_r};
      end
      default: begin
        alu_req.op = ALU_ADD;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    have_prev_nxt   = have_prev_r;
    left_found_nxt  = left_found_r;
    right_found_nxt = right_found_r;
    prof_idx_nxt    = prof_idx_r;
    good_cnt_nxt    = good_cnt_r;
    gap_sum_nxt     = gap_sum_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    x_nxt           = x_r;
    z_nxt           = z_r;
    last_nxt        = last_r;
    prev_x_nxt      = prev_x_r;
    prev_z_nxt      = prev_z_r;
    left_x_nxt      = left_x_r;
    right_x_nxt     = right_x_r;
    dz_nxt          = dz_r;
    gap_nxt         = gap_r;
    avg_nxt         = avg_r;
    hit_nxt         = hit_r;
    neg_nxt         = neg_r;
    quo_nxt         = quo_r;
    rem_nxt         = rem_r;
    out_avg_nxt     = out_avg_r;
    out_good_nxt    = out_good_r;
    out_nogood_nxt  = out_nogood_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          x_nxt    = in_tdata[23:0];
          z_nxt    = in_tdata[47:24];
          last_nxt = in_tlast;
          hit_nxt  = '0;
          if (in_tdata[47:24] != '0) begin
            state_nxt = have_prev_r ? S_DZ : S_UPD;
          end else if (in_tlast) begin
            state_nxt = S_END;
          end
        end
      end
      S_DZ: begin
        dz_nxt    = alu_res[GAP_W-1:0];
        state_nxt = S_RL;
      end
      S_RL: begin
        hit_nxt[0] = alu_neg;
        state_nxt  = S_RH;
      end
      S_RH: begin
        hit_nxt[1] = alu_neg;
        state_nxt  = S_FL;
      end
      S_FL: begin
        hit_nxt[2] = alu_neg;
        state_nxt  = S_FH;
      end
      S_FH: begin
        hit_nxt[3] = alu_neg;
        state_nxt  = S_UPD;
      end
      // latch edges on window hits, then take this point as previous
      S_UPD: begin
        if (hit_r[0] && hit_r[1]) begin
          left_x_nxt     = x_r;
          left_found_nxt = 1'b1;
        end
        if (hit_r[2] && hit_r[3]) begin
          right_x_nxt     = prev_x_r;
          right_found_nxt = 1'b1;
        end
        prev_x_nxt    = x_r;
        prev_z_nxt    = z_r;
        have_prev_nxt = 1'b1;
        state_nxt     = last_r ? S_END : S_IDLE;
      end
      S_END: begin
        state_nxt = (left_found_r && right_found_r) ? S_GAP : S_CNT;
      end
      S_GAP: begin
        gap_nxt   = alu_res[GAP_W-1:0];
        state_nxt = S_ACC;
      end
      S_ACC: begin
        gap_sum_nxt = alu_res[SUM_W-1:0];
        if (good_cnt_r < SET_MAX) good_cnt_nxt = good_cnt_r + 7'd1;
        state_nxt = S_CNT;
      end
      // profile done: clear edges, count it, maybe close the set
      S_CNT: begin
        have_prev_nxt   = 1'b0;
        left_found_nxt  = 1'b0;
        right_found_nxt = 1'b0;
        prof_idx_nxt    = pi_inc;
        if (pi_inc >= limit) begin
          if (good_cnt_r == '0) begin
            avg_nxt   = '0;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_ABS;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ABS: begin
        neg_nxt   = gap_sum_r[SUM_W-1];
        quo_nxt   = gap_sum_r[SUM_W-1] ? alu_res[SUM_W-1:0] : gap_sum_r;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      // restoring divide, one quotient bit per cycle
      S_DIV: begin
        if (!alu_neg) begin
          rem_nxt = alu_res[CNT_W-1:0];
          quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[CNT_W-2:0], quo_r[SUM_W-1]};
          quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) state_nxt = S_SIGN;
      end
      S_SIGN: begin
        avg_nxt   = neg_r ? alu_res[GAP_W-1:0] : quo_r[GAP_W-1:0];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_avg_nxt    = avg_r;
          out_good_nxt   = good_cnt_r;
          out_nogood_nxt = (good_cnt_r == '0);
          out_valid_nxt  = 1'b1;
          prof_idx_nxt   = '0;
          good_cnt_nxt   = '0;
          gap_sum_nxt    = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state, control, output and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      have_prev_r   <= 1'b0;
      left_found_r  <= 1'b0;
      right_found_r <= 1'b0;
      prof_idx_r    <= '0;
      good_cnt_r    <= '0;
      gap_sum_r     <= '0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      out_avg_r     <= '0;
      out_good_r    <= '0;
      out_nogood_r  <= 1'b0;
      rise_lo_r     <= RISE_LOW_RST;
      rise_hi_r     <= RISE_HIGH_RST;
      fall_lo_r     <= FALL_LOW_RST;
      fall_hi_r     <= FALL_HIGH_RST;
      per_set_r     <= PER_SET_RST;
    end else begin
      state_r       <= state_nxt;
      have_prev_r   <= have_prev_nxt;
      left_found_r  <= left_found_nxt;
      right_found_r <= right_found_nxt;
      prof_idx_r    <= prof_idx_nxt;
      good_cnt_r    <= good_cnt_nxt;
      gap_sum_r     <= gap_sum_nxt;
      cnt_r         <= cnt_nxt;
      out_valid_r   <= out_valid_nxt;
      out_avg_r     <= out_avg_nxt;
      out_good_r    <= out_good_nxt;
      out_nogood_r  <= out_nogood_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_RISE_LOW:  rise_lo_r <= cfg_wdata;
          REG_RISE_HIGH: rise_hi_r <= cfg_wdata;
          REG_FALL_LOW:  fall_lo_r <= cfg_wdata;
          REG_FALL_HIGH: fall_hi_r <= cfg_wdata;
          REG_PER_SET:   per_set_r <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    z_r          <= z_nxt;
    last_r       <= last_nxt;
    prev_x_r     <= prev_x_nxt;
    prev_z_r     <= prev_z_nxt;
    left_x_r     <= left_x_nxt;
    right_x_r    <= right_x_nxt;
    dz_r         <= dz_nxt;
    gap_r        <= gap_nxt;
    avg_r        <= avg_nxt;
    hit_r        <= hit_nxt;
    neg_r        <= neg_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
  end

endmodule

// ----- design/pgwa_checker.sv -----
// Port-level checks for the gap averager core, attached by bind.
// Depends on pgwa_pkg and profile_gap_width_averager_core.
module pgwa_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic [47:0]                  in_tdata,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [31:0]                  out_tdata,
  input logic                         out_tuser
);
  import pgwa_pkg::*;

  // a waiting result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // empty set flag means zero average and zero count
  a_nogood_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 32'd0)
    else $error("no-good result carries data");

  // flag clear means at least one good profile
  a_good_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[31:25] != 7'd0)
    else $error("good result with zero count");

  a_good_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:25] <= SET_MAX)
    else $error("good count above set maximum");

  // a valid point keeps the sequencer busy for the next cycle
  a_busy_after_point: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[47:24] != 24'd0) |=> !in_tready)
    else $error("ready right after a valid point");

endmodule

bind profile_gap_width_averager_core pgwa_checker u_pgwa_checker (.*);

// ----- dv/tb_profile_gap_width_averager_core.sv -----
// Testbench for profile_gap_width_averager_core: a scoreboard tracks the gap
// edges of each profile and the per-set average, and checks every output beat.
// Depends on pgwa_pkg and the core RTL; needs no files or arguments.
module tb_profile_gap_width_averager_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pgwa_pkg::*;

  localparam int SETTLE_CYCLES = 80;    // margin above the worst result latency plus output stalls
  localparam int QUIET_LIMIT   = 3000;  // cycles without any beat before giving up
  localparam int Z_MIN         = -8388608;
  localparam int Z_MAX         = 8388607;
  localparam int PRINT_MAX     = 40;

  typedef struct packed {
    logic [GAP_W-1:0] avg;
    logic [CNT_W-1:0] good;
    logic             none;
  } gap_result_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCK} rx_mode_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [47:0]         in_tdata   = '0;   // x_um[23:0], z_um[47:24]
  logic                in_tlast   = 1'b0; // last_point
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [31:0]         out_tdata;         // average_gap_um[24:0], good_profiles[31:25]
  logic                out_tuser;         // no_good_profile
  logic                cfg_we     = 1'b0;
  logic [IDX_W-1:0]    cfg_addr   = '0;
  logic [COORD_W-1:0]  cfg_wdata  = '0;

  profile_gap_width_averager_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Scoreboard copy of the block: window settings, profile and set state
  int          win_rise_lo, win_rise_hi, win_fall_lo, win_fall_hi;
  logic [6:0]  set_size_reg;
  int          edge_prev_x, edge_prev_z, edge_left_x, edge_right_x;
  bit          edge_have_prev, edge_left_found, edge_right_found;
  int          set_profile_idx, set_good_cnt, set_gap_sum;
  gap_result_t gap_results_q[$];

  // Stimulus state
  int gen_x, gen_z;
  int burst_left   = 0;
  int points_sent  = 0;
  int profiles_run = 0;
  int results_seen = 0;
  int sets_closed  = 0;
  int fail_count   = 0;
  int quiet_cycles = 0;
  int reg_writes   = 0;

  function automatic int sx24(logic [23:0] v);
    return int'($signed(v));
  endfunction

  task automatic reset_tracker();
    win_rise_lo = sx24(RISE_LOW_RST);
    win_rise_hi = sx24(RISE_HIGH_RST);
    win_fall_lo = sx24(FALL_LOW_RST);
    win_fall_hi = sx24(FALL_HIGH_RST);
    set_size_reg = PER_SET_RST;
    edge_prev_x = 0; edge_prev_z = 0; edge_have_prev = 0;
    edge_left_x = 0; edge_right_x = 0; edge_left_found = 0; edge_right_found = 0;
    set_profile_idx = 0; set_good_cnt = 0; set_gap_sum = 0;
    gen_x = 0;
    gen_z = 1000;
  endtask

  // Edge tracking and set averaging for one accepted point
  task automatic track_gap_point(input int x, input int z, input bit last);
    int          dz;
    int          lim;
    int          avg;
    gap_result_t res;
    if (z != 0) begin
      if (edge_have_prev) begin
        dz = z - edge_prev_z;
        if (dz > win_rise_lo && dz < win_rise_hi) begin
          edge_left_x = x;
          edge_left_found = 1;
        end
        if (dz > win_fall_lo && dz < win_fall_hi) begin
          edge_right_x = edge_prev_x;
          edge_right_found = 1;
        end
      end
      edge_prev_x = x;
      edge_prev_z = z;
      edge_have_prev = 1;
    end
    if (last) begin
      profiles_run++;
      if (edge_left_found && edge_right_found) begin
        set_gap_sum += edge_right_x - edge_left_x;
        if (set_good_cnt < int'(SET_MAX)) set_good_cnt++;
      end
      edge_prev_x = 0; edge_prev_z = 0; edge_have_prev = 0;
      edge_left_x = 0; edge_right_x = 0; edge_left_found = 0; edge_right_found = 0;
      // zero acts as one, anything above the maximum acts as the maximum
      lim = int'(set_size_reg);
      if (lim < 1) lim = 1;
      if (lim > int'(SET_MAX)) lim = int'(SET_MAX);
      if (set_profile_idx < int'(SET_MAX)) set_profile_idx++;
      if (set_profile_idx >= lim) begin
        avg = (set_good_cnt != 0) ? set_gap_sum / set_good_cnt : 0;
        res.avg  = GAP_W'(avg);
        res.good = CNT_W'(set_good_cnt);
        res.none = (set_good_cnt == 0);
        gap_results_q.push_back(res);
        sets_closed++;
        set_profile_idx = 0; set_good_cnt = 0; set_gap_sum = 0;
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= PRINT_MAX)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // One register write, then write enable held low, so it never toggles twice in a step
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RISE_LOW:  win_rise_lo = sx24(val);
      REG_RISE_HIGH: win_rise_hi = sx24(val);
      REG_FALL_LOW:  win_fall_lo = sx24(val);
      REG_FALL_HIGH: win_fall_hi = sx24(val);
      REG_PER_SET:   set_size_reg = val[6:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  // Set size write with random junk in the bits above the register
  task automatic write_set_size(input int n);
    write_reg(REG_PER_SET, {17'($urandom), 7'(n)});
  endtask

  // Send one point beat; burst/gap pacing follows each accepted beat
  task automatic send_point(input int x, input int z, input bit last);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {24'(z), 24'(x)};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_gap_point(sx24(24'(x)), sx24(24'(z)), last);
    points_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(150, 300)
                                              : $urandom_range(0, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every expected average is out, then let the core go idle
  task automatic settle();
    in_tvalid <= 1'b0;
    while (gap_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Generator: emits a point with the given height at the next lateral position
  task automatic emit_point(input int z, input bit last);
    gen_x += $urandom_range(1, 400);
    if ($urandom_range(0, 29) == 0) gen_x = $urandom;
    gen_x = sx24(24'(gen_x));
    send_point(gen_x, z, last);
    if (z != 0) gen_z = z;
  endtask

  // Emits a point whose height is dz above the last valid one; re-bases if out of range
  task automatic emit_step(input int dz, input bit last);
    longint tgt;
    int     base;
    tgt = longint'(gen_z) + dz;
    if (tgt > Z_MAX || tgt < Z_MIN) begin
      base = (dz >= 0) ? -(dz - dz / 2) : -(dz / 2);
      if (base == 0) base = 1;
      emit_point(base, 1'b0);
      tgt = longint'(base) + dz;
    end
    emit_point(int'(tgt), last);
  endtask

  // Step strictly inside (lo, hi), or a small step when the window is empty
  task automatic emit_window_step(input int lo, input int hi, input bit last);
    longint span;
    span = longint'(hi) - lo - 1;
    if (span >= 1) emit_step(int'(longint'(lo) + 1 + longint'($urandom) % span), last);
    else emit_step($urandom_range(0, 60) - 30, last);
  endtask

  task automatic emit_filler(input bit last);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)       emit_point(0, last);
    else if (r < 14) emit_point(sx24(24'($urandom)), last);
    else if (r < 20) emit_step($urandom_range(0, 40000) - 20000, last);
    else             emit_step($urandom_range(0, 60) - 30, last);
  endtask

  // Shaped profile: flat, rising step, flat, falling step, flat; else all noise
  task automatic send_profile(input int n_pts, input bit shaped);
    int  rise_at, fall_at, r;
    bit  last;
    rise_at = -1;
    fall_at = -1;
    if (shaped && n_pts >= 2) begin
      rise_at = $urandom_range(1, (n_pts > 2) ? n_pts - 2 : 1);
      if (rise_at + 1 <= n_pts - 1) fall_at = $urandom_range(rise_at + 1, n_pts - 1);
    end
    for (int i = 0; i < n_pts; i++) begin
      last = (i == n_pts - 1);
      if (last && $urandom_range(0, 99) < 12) begin
        emit_point(0, 1'b1);
      end else if (i == rise_at) begin
        emit_window_step(win_rise_lo, win_rise_hi, last);
      end else if (i == fall_at) begin
        emit_window_step(win_fall_lo, win_fall_hi, last);
      end else if (!shaped) begin
        r = $urandom_range(0, 3);
        if (r == 0)      emit_window_step(win_rise_lo, win_rise_hi, last);
        else if (r == 1) emit_window_step(win_fall_lo, win_fall_hi, last);
        else             emit_filler(last);
      end else begin
        emit_filler(last);
      end
    end
  endtask

  task automatic send_profiles(input int count, input int min_pts, input int max_pts);
    for (int p = 0; p < count; p++)
      send_profile($urandom_range(min_pts, max_pts), $urandom_range(0, 99) < 85);
  endtask

  task automatic pick_window(output int lo, output int hi, input int dflt_lo, input int dflt_hi);
    case ($urandom_range(0, 4))
      0: begin
        lo = int'($urandom_range(0, 4000000)) - 2000000;
        hi = lo + int'($urandom_range(2, 30000));
      end
      1: begin
        lo = Z_MIN;
        hi = Z_MAX;
      end
      2: begin
        lo = sx24(24'($urandom));
        hi = lo - int'($urandom_range(0, 1000));
      end
      3: begin
        lo = sx24(24'($urandom));
        hi = sx24(24'($urandom));
      end
      default: begin
        lo = dflt_lo;
        hi = dflt_hi;
      end
    endcase
  endtask

  task automatic set_random_windows();
    int lo, hi;
    pick_window(lo, hi, sx24(RISE_LOW_RST), sx24(RISE_HIGH_RST));
    write_reg(REG_RISE_LOW, 24'(lo));
    write_reg(REG_RISE_HIGH, 24'(hi));
    pick_window(lo, hi, sx24(FALL_LOW_RST), sx24(FALL_HIGH_RST));
    write_reg(REG_FALL_LOW, 24'(lo));
    write_reg(REG_FALL_HIGH, 24'(hi));
  endtask

  // Directed: reset windows and reset set size; gap averaging truncates toward zero,
  // an invalid last point still closes a profile, one-sided and empty profiles
  task automatic test_reset_set();
    // good profile, gap -7
    send_point(1000, 1000, 0);
    send_point(1010, 8000, 0);
    send_point(1003, 8000, 0);
    send_point(1020, 5300, 1);
    // good profile, gap 2, closed by an invalid point
    send_point(0, 1000, 0);
    send_point(10, 8000, 0);
    send_point(12, 8000, 0);
    send_point(20, 5300, 0);
    send_point(30, 0, 1);
    // field extremes as one-point profiles, then an empty profile
    send_point(Z_MAX, Z_MAX, 1);
    send_point(Z_MIN, Z_MIN, 1);
    send_point(0, 0, 1);
    // left edge only, right edge only
    send_point(0, 100, 0);
    send_point(5, 6100, 1);
    send_point(0, 9000, 0);
    send_point(5, 6300, 1);
    for (int i = 0; i < 13; i++)
      send_point(i * 1000 - 7000, (i % 2) ? 0 : i * 37 + 1, 1);
    settle();
  endtask

  // Directed: set size zero acts as one; no good profile; largest and smallest gaps
  task automatic test_set_size_limits();
    write_set_size(0);
    send_point(0, 0, 1);
    send_point(0, 1000, 0);
    send_point(Z_MIN, 8000, 0);
    send_point(Z_MAX, 8000, 0);
    send_point(5, 5300, 1);
    send_point(0, 1000, 0);
    send_point(Z_MAX, 8000, 0);
    send_point(Z_MIN, 8000, 0);
    send_point(0, 5300, 1);
    settle();
  endtask

  // Random profiles with every register rewritten to its reset value
  task automatic test_rand_reset_windows();
    write_reg(REG_RISE_LOW, RISE_LOW_RST);
    write_reg(REG_RISE_HIGH, RISE_HIGH_RST);
    write_reg(REG_FALL_LOW, FALL_LOW_RST);
    write_reg(REG_FALL_HIGH, FALL_HIGH_RST);
    write_reg(REG_PER_SET, {17'($urandom), PER_SET_RST});
    send_profiles(40, 3, 10);
    settle();
  endtask

  // Random windows, small sets, and writes to unused indexes that must change nothing
  task automatic test_rand_small_sets();
    for (int round = 0; round < 8; round++) begin
      set_random_windows();
      write_reg(IDX_W'($urandom_range(int'(REG_PER_SET) + 1, (1 << IDX_W) - 1)),
                24'($urandom));
      write_set_size($urandom_range(0, 5));
      send_profiles(25, 2, 10);
      settle();
    end
  endtask

  // Largest set size with one set's worth of short profiles
  task automatic test_rand_full_set();
    write_set_size(int'(SET_MAX));
    send_profiles(64, 1, 5);
    settle();
  endtask

  // Oversized setting, then lowered below the profiles already counted
  task automatic test_rand_shrink_mid_set();
    write_set_size($urandom_range(65, 127));
    send_profiles(10, 2, 8);
    settle();
    write_set_size($urandom_range(1, 9));
    send_profiles(15, 2, 8);
    settle();
  endtask

  // Receiver stall pattern: open, coin flip, sparse and blocked stretches
  rx_mode_t rx_mode  = RX_OPEN;
  int       rx_left  = 0;
  int       rx_phase = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(40, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_phase <= rx_phase + 1;
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= (rx_phase % 5 == 0);
      default:   out_tready <= (rx_phase % 24 == 0);
    endcase
  end

  // Result check against the oldest expected average
  always @(posedge clk) begin : check_results
    gap_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (gap_results_q.size() == 0) begin
        flag_mismatch("unexpected result beat, average", int'($signed(out_tdata[24:0])), 0);
      end else begin
        want = gap_results_q.pop_front();
        results_seen++;
        if (out_tdata[24:0] !== want.avg)
          flag_mismatch("average_gap_um", int'($signed(out_tdata[24:0])),
                        int'($signed(want.avg)));
        if (out_tdata[31:25] !== want.good)
          flag_mismatch("good_profiles", int'(out_tdata[31:25]), int'(want.good));
        if (out_tuser !== want.none)
          flag_mismatch("no_good_profile", int'(out_tuser), int'(want.none));
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               quiet_cycles, gap_results_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    reset_tracker();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_set();
    test_set_size_limits();
    test_rand_reset_windows();
    test_rand_small_sets();
    test_rand_full_set();
    test_rand_shrink_mid_set();
    $display("run covered %0d points in %0d profiles and %0d register writes",
             points_sent, profiles_run, reg_writes);
    $display("%0d set averages checked, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
